FILE: sv/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared command codes, result kinds and the queue entry type.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int CMD_W = 4;
    localparam int LIT_W = 32;
    localparam int VAL_W = 64;
    localparam int KIND_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PTOP  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_PALL  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ADD   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_SUB   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_MUL   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DIV   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_MOD   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_DUP   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_SWAP  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 4'd10;

    localparam logic [KIND_W-1:0] KIND_VALUE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIV0   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MOD0   = 2'd2;

    // classified word passed from front to back
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] lit;
    } cmd_word_t;

endpackage

FILE: sv/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Postfix 64-bit integer stack machine with a command queue and executor.
// ----------------------------------------------------------------------------
// Commands enter through a two-word queue; start is taken when busy is low,
// and busy is high only while both queue words wait. The executor takes a
// word from the queue when it is idle. Mul uses split 32-bit partial
// products, div/mod uses one quotient bit per cycle in the shared divider,
// and print all reads one entry at a time (one stack memory read port).
// Results appear for one cycle with strobe high and cannot be held off.
// After a divide or modulo by zero the block ignores all commands until reset.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         command,
    input  logic signed [31:0] literal,
    output logic               strobe,
    output logic signed [63:0] result_value,
    output logic [1:0]         result_kind,
    output logic               last_of_run
);
    import rpn_pkg::*;

    logic      q_valid, q_pop, halted;
    cmd_word_t q_word;
    logic [63:0] value;

    rpn_front u_front (
        .clk (clk), .rst_n (rst_n), .start (start), .busy (busy),
        .command (command), .literal (literal), .halted (halted),
        .q_valid (q_valid), .q_word (q_word), .q_pop (q_pop)
    );

    rpn_back #(.STACK_DEPTH (STACK_DEPTH)) u_back (
        .clk (clk), .rst_n (rst_n), .q_valid (q_valid), .q_word (q_word),
        .q_pop (q_pop), .halted (halted), .strobe (strobe),
        .result_value (value), .result_kind (result_kind),
        .last_of_run (last_of_run)
    );

    assign result_value = value;

endmodule

FILE: sv/rpn_front.sv
// ----------------------------------------------------------------------------
// rpn_front
// Takes command words, drops unused codes, sign-extends the literal and
// queues the word for the execution unit.
// ----------------------------------------------------------------------------
module rpn_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [3:0]        command,
    input  logic signed [31:0] literal,
    input  logic              halted,
    output logic              q_valid,
    output rpn_pkg::cmd_word_t q_word,
    input  logic              q_pop
);
    import rpn_pkg::*;

    // two-entry queue
    cmd_word_t mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      push;

    assign busy = (cnt_reg == 2'd2);
    // unused codes and commands while halted need no execution
    assign push = start && !busy && !halted && (command <= CMD_CLEAR);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= '{cmd: command, lit: {{32{literal[31]}}, literal}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (q_pop && q_valid)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("bad queue count");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");

endmodule

FILE: sv/rpn_divider.sv
// ----------------------------------------------------------------------------
// rpn_divider
// Signed 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] quo,
    output logic [63:0] rem
);
    import rpn_pkg::*;

    logic        run_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] q_reg, r_reg, d_reg;
    logic        nq_reg, nr_reg;
    logic [64:0] trial;

    assign trial = {r_reg, q_reg[63]} - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= 7'd0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 7'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg  <= a[63] ? 64'd0 - a : a;
            d_reg  <= b[63] ? 64'd0 - b : b;
            r_reg  <= 64'd0;
            nq_reg <= a[63] ^ b[63];
            nr_reg <= a[63];
        end
        else if (run_reg)
        begin
            if (!trial[64])
            begin
                r_reg <= trial[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[62:0], q_reg[63]};
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign quo = nq_reg ? 64'd0 - q_reg : q_reg;
    assign rem = nr_reg ? 64'd0 - r_reg : r_reg;

endmodule

FILE: sv/rpn_back.sv
// ----------------------------------------------------------------------------
// rpn_back
// Execution unit: stack memory, arithmetic and result sequencing.
// ----------------------------------------------------------------------------
module rpn_back #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  rpn_pkg::cmd_word_t q_word,
    output logic               q_pop,
    output logic               halted,
    output logic               strobe,
    output logic [63:0]        result_value,
    output logic [1:0]         result_kind,
    output logic               last_of_run
);
    import rpn_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_OP, S_MUL, S_DIVW, S_WR, S_WR2, S_PRINT
    } state_t;

    state_t state_reg;
    logic [63:0] mem [STACK_DEPTH];
    logic [63:0] rd_reg, a_reg, b_reg, res_reg;
    logic [AW-1:0] raddr, waddr_reg;
    logic [DW-1:0] depth_reg, ptr_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic        wr_en;
    logic [63:0] wr_data;
    logic [AW-1:0] wr_addr;
    logic        div_go, div_done;
    logic [63:0] div_q, div_r;
    logic [63:0] mul_lo_reg, mul_x_reg, mul_y_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[raddr];
    end

    rpn_divider u_div (
        .clk (clk), .rst_n (rst_n), .go (div_go), .a (a_reg), .b (b_reg),
        .done (div_done), .quo (div_q), .rem (div_r)
    );

    // once halted, queued words are drained and dropped
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign div_go = (state_reg == S_OP) && (cmd_reg == CMD_DIV || cmd_reg == CMD_MOD)
                    && (b_reg != 64'd0);

    // read address follows the pointer register
    assign raddr = AW'(ptr_reg - DW'(1));

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = waddr_reg;
        wr_data = res_reg;
        case (state_reg)
            S_WR:    wr_en = 1'b1;
            S_WR2:
            begin
                wr_en = 1'b1;
                wr_data = a_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            halted <= 1'b0;
            strobe <= 1'b0;
            last_of_run <= 1'b0;
            result_kind <= KIND_VALUE;
            ptr_reg <= '0;
        end
        else
        begin
            strobe <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && !halted)
                    begin
                        cmd_reg <= q_word.cmd;
                        ptr_reg <= depth_reg;
                        a_reg <= 64'd0;
                        b_reg <= 64'd0;
                        case (q_word.cmd)
                            CMD_PUSH:
                            begin
                                if (depth_reg < DW'(STACK_DEPTH))
                                begin
                                    res_reg <= q_word.lit;
                                    waddr_reg <= AW'(depth_reg);
                                    depth_reg <= depth_reg + DW'(1);
                                    state_reg <= S_WR;
                                end
                            end
                            CMD_CLEAR: depth_reg <= '0;
                            CMD_PTOP, CMD_PALL, CMD_DUP:
                                if (depth_reg != '0) state_reg <= S_RD1;
                            CMD_SWAP:
                                if (depth_reg >= DW'(2)) state_reg <= S_RD1;
                            default: state_reg <= S_RD1;
                        endcase
                    end
                end
                S_RD1:
                begin
                    // memory read of entry ptr-1 lands next cycle
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    case (cmd_reg)
                        CMD_PTOP, CMD_PALL:
                        begin
                            result_value <= rd_reg;
                            result_kind <= KIND_VALUE;
                            strobe <= 1'b1;
                            last_of_run <= (cmd_reg == CMD_PTOP) || (ptr_reg == DW'(1));
                            if (cmd_reg == CMD_PALL && ptr_reg != DW'(1))
                            begin
                                ptr_reg <= ptr_reg - DW'(1);
                                state_reg <= S_RD1;
                            end
                            else
                                state_reg <= S_IDLE;
                        end
                        CMD_DUP:
                        begin
                            if (depth_reg < DW'(STACK_DEPTH))
                            begin
                                res_reg <= rd_reg;
                                waddr_reg <= AW'(depth_reg);
                                depth_reg <= depth_reg + DW'(1);
                                state_reg <= S_WR;
                            end
                            else
                                state_reg <= S_IDLE;
                        end
                        CMD_SWAP:
                        begin
                            if (ptr_reg == depth_reg)
                            begin
                                a_reg <= rd_reg;
                                ptr_reg <= ptr_reg - DW'(1);
                                state_reg <= S_RD1;
                            end
                            else
                            begin
                                // rd is second entry, a is old top
                                res_reg <= rd_reg;
                                waddr_reg <= AW'(depth_reg - DW'(1));
                                state_reg <= S_WR;
                            end
                        end
                        default:
                        begin
                            // binary op: pop b then a, empty pops give zero
                            if (ptr_reg == depth_reg)
                            begin
                                if (depth_reg != '0) b_reg <= rd_reg;
                                if (depth_reg > DW'(1))
                                begin
                                    ptr_reg <= ptr_reg - DW'(1);
                                    state_reg <= S_RD1;
                                end
                                else
                                begin
                                    depth_reg <= '0;
                                    state_reg <= S_OP;
                                end
                            end
                            else
                            begin
                                a_reg <= rd_reg;
                                depth_reg <= depth_reg - DW'(2);
                                state_reg <= S_OP;
                            end
                        end
                    endcase
                end
                S_OP:
                begin
                    waddr_reg <= AW'(depth_reg);
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            res_reg <= a_reg + b_reg;
                            depth_reg <= depth_reg + DW'(1);
                            state_reg <= S_WR;
                        end
                        CMD_SUB:
                        begin
                            res_reg <= a_reg - b_reg;
                            depth_reg <= depth_reg + DW'(1);
                            state_reg <= S_WR;
                        end
                        CMD_MUL:
                        begin
                            mul_lo_reg <= 64'(a_reg[31:0] * b_reg[31:0]);
                            mul_x_reg <= 64'(a_reg[63:32] * b_reg[31:0]);
                            mul_y_reg <= 64'(a_reg[31:0] * b_reg[63:32]);
                            state_reg <= S_MUL;
                        end
                        default:
                        begin
                            if (b_reg == 64'd0)
                            begin
                                result_value <= 64'd0;
                                result_kind <= (cmd_reg == CMD_DIV) ? KIND_DIV0 : KIND_MOD0;
                                last_of_run <= 1'b1;
                                strobe <= 1'b1;
                                halted <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                                state_reg <= S_DIVW;
                        end
                    endcase
                end
                S_MUL:
                begin
                    res_reg <= mul_lo_reg + {mul_x_reg[31:0] + mul_y_reg[31:0], 32'd0};
                    depth_reg <= depth_reg + DW'(1);
                    state_reg <= S_WR;
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        res_reg <= (cmd_reg == CMD_DIV) ? div_q : div_r;
                        depth_reg <= depth_reg + DW'(1);
                        state_reg <= S_WR;
                    end
                end
                S_WR:
                begin
                    state_reg <= (cmd_reg == CMD_SWAP) ? S_WR2 : S_IDLE;
                    waddr_reg <= AW'(depth_reg - DW'(2));
                end
                S_WR2: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(STACK_DEPTH)) else $error("depth out of range");
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $past(halted) |-> !strobe) else $error("result while halted");
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result_kind != KIND_VALUE |-> last_of_run && halted)
        else $error("error result not final");

endmodule
